// ===== sv/lab_pkg.sv =====
// Shared types and constants of the life automaton board.
package lab_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]       op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cell_value;
    } item_t;

    typedef struct packed {
        logic cell_alive;
        logic coord_error;
    } result_t;

    typedef struct packed {
        logic cap_item;
        logic rd_item;
        logic merge;
        logic gen_init;
        logic gen_load0;
        logic gen_row;
        logic out_load;
    } lab_cmd_t;

    typedef struct packed {
        logic rw_ok;
        logic gen_go;
        logic gen_last;
    } lab_stat_t;

endpackage

// ===== sv/lab_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lab_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lab_ctrl.sv =====
// Controller state machine of the life automaton board.
module lab_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  lab_pkg::lab_stat_t  stat,
    output lab_pkg::lab_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MRG  = 3'd2;
    localparam logic [2:0] S_G0   = 3'd3;
    localparam logic [2:0] S_GR   = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.rw_ok)
                begin
                    cmd.rd_item = 1'b1;
                    state_next  = S_MRG;
                end
                else if (stat.gen_go)
                begin
                    cmd.gen_init = 1'b1;
                    state_next   = S_G0;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_MRG:
            begin
                cmd.merge  = 1'b1;
                state_next = S_RES;
            end
            S_G0:
            begin
                cmd.gen_load0 = 1'b1;
                state_next    = S_GR;
            end
            S_GR:
            begin
                cmd.gen_row = 1'b1;
                if (stat.gen_last)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// ===== sv/lab_dp.sv =====
// Datapath of the life automaton board: size registers, row window and board RAM.
module lab_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lab_pkg::item_t                      item,
    output lab_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lab_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lab_pkg::SIZE_W-1:0]          cfg_data,
    input  lab_pkg::lab_cmd_t                   cmd,
    output lab_pkg::lab_stat_t                  stat
);

    localparam int RW = lab_pkg::MAX_COLS;
    localparam int AW = lab_pkg::ROW_W;
    localparam int SW = lab_pkg::SIZE_W;

    logic [SW-1:0]              rows_reg, rows_next;
    logic [SW-1:0]              cols_reg, cols_next;
    logic [lab_pkg::MAX_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                       rd_valid_reg, rd_valid_next;
    lab_pkg::item_t             item_reg, item_next;
    logic                       alive_reg, alive_next;
    lab_pkg::result_t           result_reg, result_next;
    logic [AW-1:0]              gen_r_reg, gen_r_next;
    logic [RW-1:0]              prev_reg, prev_next;
    logic [RW-1:0]              cur_reg, cur_next;

    logic [SW-1:0]  nrows;
    logic [SW-1:0]  ncols;
    logic           coord_bad;
    logic           is_rw;
    logic [RW-1:0]  col_mask;
    logic [RW-1:0]  rdata;
    logic [RW-1:0]  rdata_v;
    logic [RW-1:0]  next_row;
    logic [RW+1:0]  up_x;
    logic [RW+1:0]  mid_x;
    logic [RW+1:0]  dn_x;
    logic [RW-1:0]  life_row;
    logic [RW-1:0]  new_row;
    logic [RW-1:0]  merged_row;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [RW-1:0]  wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    function automatic logic cell_next(input logic [2:0] up, input logic [2:0] mid,
                                       input logic [2:0] dn);
        logic [3:0] cnt;
        cnt = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
            + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
        return (cnt == 4'd3) || ((cnt == 4'd2) && mid[1]);
    endfunction

    assign nrows = (rows_reg > SW'(lab_pkg::MAX_ROWS)) ? SW'(lab_pkg::MAX_ROWS) : rows_reg;
    assign ncols = (cols_reg > SW'(lab_pkg::MAX_COLS)) ? SW'(lab_pkg::MAX_COLS) : cols_reg;

    assign is_rw     = item_reg.op inside {lab_pkg::OP_WRITE, lab_pkg::OP_READ};
    assign coord_bad = (SW'(item_reg.row) >= nrows) || (SW'(item_reg.col) >= ncols);

    assign stat.rw_ok    = is_rw && !coord_bad;
    assign stat.gen_go   = (item_reg.op == lab_pkg::OP_ADVANCE) && (nrows != '0);
    assign stat.gen_last = ((SW'(gen_r_reg) + SW'(1)) == nrows);

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int c = 0; c < RW; c++)
        begin
            col_mask[c] = (SW'(c) < ncols);
        end
    end

    assign rdata_v  = rd_valid_reg ? rdata : '0;
    assign next_row = ((SW'(gen_r_reg) + SW'(1)) < nrows) ? rdata_v : '0;

    assign up_x  = {1'b0, prev_reg & col_mask, 1'b0};
    assign mid_x = {1'b0, cur_reg & col_mask, 1'b0};
    assign dn_x  = {1'b0, next_row & col_mask, 1'b0};

    always_comb
    begin
        for (int c = 0; c < RW; c++)
        begin
            life_row[c] = cell_next(up_x[c +: 3], mid_x[c +: 3], dn_x[c +: 3]);
        end
    end

    assign new_row    = (life_row & col_mask) | (cur_reg & ~col_mask);
    assign merged_row = (rdata_v & ~(RW'(1) << item_reg.col))
                      | (RW'(item_reg.cell_value) << item_reg.col);

    always_comb
    begin
        wr_en   = cmd.gen_row || (cmd.merge && (item_reg.op == lab_pkg::OP_WRITE));
        wr_addr = cmd.gen_row ? gen_r_reg : item_reg.row;
        wr_data = cmd.gen_row ? new_row : merged_row;
        rd_en   = cmd.rd_item || cmd.gen_init || cmd.gen_load0 || cmd.gen_row;
        if (cmd.gen_init)
        begin
            rd_addr = '0;
        end
        else if (cmd.gen_load0)
        begin
            rd_addr = AW'(1);
        end
        else if (cmd.gen_row)
        begin
            rd_addr = gen_r_reg + AW'(2);
        end
        else
        begin
            rd_addr = item_reg.row;
        end
    end

    always_comb
    begin
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        item_next      = item_reg;
        alive_next     = alive_reg;
        result_next    = result_reg;
        gen_r_next     = gen_r_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                lab_pkg::REG_BOARD_ROWS: rows_next = cfg_data;
                lab_pkg::REG_BOARD_COLS: cols_next = cfg_data;
                default: ;
            endcase
        end
        if (cmd.cap_item)
        begin
            item_next = item;
        end
        if (rd_en)
        begin
            rd_valid_next = row_valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        if (cmd.merge)
        begin
            alive_next = rdata_v[item_reg.col];
        end
        if (cmd.gen_init)
        begin
            gen_r_next = '0;
            prev_next  = '0;
        end
        if (cmd.gen_load0)
        begin
            cur_next = rdata_v;
        end
        if (cmd.gen_row)
        begin
            prev_next  = cur_reg;
            cur_next   = next_row;
            gen_r_next = gen_r_reg + AW'(1);
        end
        if (cmd.out_load)
        begin
            result_next.cell_alive  = (item_reg.op == lab_pkg::OP_READ) && !coord_bad
                                      && alive_reg;
            result_next.coord_error = is_rw && coord_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= lab_pkg::SIZE_RESET;
            cols_reg      <= lab_pkg::SIZE_RESET;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        alive_reg  <= alive_next;
        result_reg <= result_next;
        gen_r_reg  <= gen_r_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
    end

    assign result = result_reg;

    lab_ram #(
        .WIDTH(RW),
        .DEPTH(lab_pkg::MAX_ROWS)
    ) u_board (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rdata)
    );

endmodule

// ===== sv/life_automaton_board_unit.sv =====
// Top level of the life automaton board (B3/S23 rule, one-bit cells).
//
// Item channel (item_valid/item_ready/item) carries one beat per operation:
// write cell, read cell or advance one generation. Result channel
// (result_valid/result_ready/result) returns exactly one beat per item.
// The cfg channel writes the row and column count registers; it is always
// ready; the user must see that it is written only while the block is idle;
// the block itself does not enforce this. The board is a RAM of one
// 64-bit word per row. A read or write issues one RAM read in DEC and,
// for a write, one row write in MRG; its result is loaded in RES, after
// which the controller returns to IDLE for the next item. A bad coordinate
// or the spare op code goes from DEC straight to RES. A generation sweeps
// the active rows through a three-row window, one row per cycle.
// Reset clears the size registers to 64 and marks every row as dead through
// per-row valid bits, so no clearing pass is needed.
// A result waits in its output register while the receiver stalls; the next
// item is accepted meanwhile and holds in its final step until the register
// frees.
module life_automaton_board_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  lab_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output lab_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lab_pkg::SIZE_W-1:0]    cfg_data
);

    lab_pkg::lab_cmd_t  cmd;
    lab_pkg::lab_stat_t stat;

    lab_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    lab_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== bench/life_automaton_board_unit_tb.sv =====
// Self-checking testbench for the life automaton board: cell writes, reads and generation steps.
`timescale 1ns / 100ps

module life_automaton_board_unit_tb;

    localparam int          CELLS        = lab_pkg::MAX_ROWS * lab_pkg::MAX_COLS;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_AT      = 70;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  OP_SPARE     = 2'd3;
    localparam logic [lab_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [lab_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           item_valid   = 1'b0;
    logic                           item_ready;
    lab_pkg::item_t                 item         = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    lab_pkg::result_t               result;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [lab_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [lab_pkg::SIZE_W-1:0]     cfg_data     = '0;

    life_automaton_board_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // board mirror and size registers
    bit                         board_now  [CELLS];
    bit                         board_prev [CELLS];
    logic [lab_pkg::SIZE_W-1:0] size_rows = lab_pkg::SIZE_RESET;
    logic [lab_pkg::SIZE_W-1:0] size_cols = lab_pkg::SIZE_RESET;

    lab_pkg::item_t   pending_ops[$];
    lab_pkg::result_t awaited_results[$];

    bit          item_taken      = 1'b0;
    bit          sender_idles    = 1'b0;
    bit          receiver_stalls = 1'b0;
    int unsigned send_gap        = 0;
    int unsigned stall_left      = 0;
    int unsigned hold_left       = 0;
    bit          hold_done       = 1'b0;
    int unsigned items_in        = 0;
    int unsigned results_out     = 0;
    int unsigned writes_seen     = 0;
    int unsigned reads_seen      = 0;
    int unsigned steps_seen      = 0;
    int unsigned errors_seen     = 0;
    int unsigned size_settings   = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    function automatic int clip_size(logic [lab_pkg::SIZE_W-1:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic void next_generation();
        int nr;
        int nc;
        int r;
        int c;
        int dr;
        int dc;
        int rr;
        int cc;
        int n;
        nr = clip_size(size_rows, lab_pkg::MAX_ROWS);
        nc = clip_size(size_cols, lab_pkg::MAX_COLS);
        board_prev = board_now;
        for (r = 0; r < nr; r++)
        begin
            for (c = 0; c < nc; c++)
            begin
                n = 0;
                for (dr = -1; dr <= 1; dr++)
                begin
                    for (dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if (!(dr == 0 && dc == 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                            n += board_prev[rr * lab_pkg::MAX_COLS + cc];
                    end
                end
                if (n == 3)
                    board_now[r * lab_pkg::MAX_COLS + c] = 1'b1;
                else if (n != 2)
                    board_now[r * lab_pkg::MAX_COLS + c] = 1'b0;
            end
        end
    endfunction

    function automatic lab_pkg::result_t apply_board_op(lab_pkg::item_t op_item);
        lab_pkg::result_t res;
        int               nr;
        int               nc;
        int               idx;
        res = '0;
        nr  = clip_size(size_rows, lab_pkg::MAX_ROWS);
        nc  = clip_size(size_cols, lab_pkg::MAX_COLS);
        idx = int'(op_item.row) * lab_pkg::MAX_COLS + int'(op_item.col);
        case (op_item.op)
            lab_pkg::OP_WRITE, lab_pkg::OP_READ:
            begin
                if (int'(op_item.row) >= nr || int'(op_item.col) >= nc)
                    res.coord_error = 1'b1;
                else if (op_item.op == lab_pkg::OP_WRITE)
                    board_now[idx] = op_item.cell_value;
                else
                    res.cell_alive = board_now[idx];
            end
            lab_pkg::OP_ADVANCE:
                next_generation();
            default:
                ;
        endcase
        return res;
    endfunction

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap   = send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                item       <= pending_ops.pop_front();
                item_valid <= 1'b1;
                if (sender_idles && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!hold_done && items_in >= HOLD_AT)
        begin
            hold_done    = 1'b1;
            hold_left    = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   = stall_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= rst_n;
            if (receiver_stalls && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 19);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        lab_pkg::result_t want;
        item_taken = item_valid && item_ready;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_out++;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result beat: cell_alive %0b coord_error %0b",
                                 result.cell_alive, result.coord_error);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.cell_alive !== result.cell_alive ||
                        want.coord_error !== result.coord_error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"result %0d: cell_alive exp %0b got %0b, ",
                                      "coord_error exp %0b got %0b"},
                                     results_out, want.cell_alive, result.cell_alive,
                                     want.coord_error, result.coord_error);
                    end
                end
            end
            if (item_taken)
            begin
                items_in++;
                want = apply_board_op(item);
                awaited_results.push_back(want);
                if (item.op == lab_pkg::OP_WRITE)
                    writes_seen++;
                else if (item.op == lab_pkg::OP_READ)
                    reads_seen++;
                else if (item.op == lab_pkg::OP_ADVANCE)
                    steps_seen++;
                if (want.coord_error)
                    errors_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, awaited_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_ops.size() != 0 || item_valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [lab_pkg::CFG_IDX_W-1:0] idx,
                             logic [lab_pkg::SIZE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lab_pkg::REG_BOARD_ROWS)
            size_rows = data;
        else if (idx == lab_pkg::REG_BOARD_COLS)
            size_cols = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_board_size(logic [lab_pkg::SIZE_W-1:0] rows,
                                  logic [lab_pkg::SIZE_W-1:0] cols);
        wait_idle();
        cfg_write(lab_pkg::REG_BOARD_ROWS, rows);
        cfg_write(lab_pkg::REG_BOARD_COLS, cols);
        size_settings++;
    endtask

    task automatic post(logic [1:0] op, int r, int c, bit v);
        lab_pkg::item_t it;
        it.op         = op;
        it.row        = r[lab_pkg::ROW_W-1:0];
        it.col        = c[lab_pkg::COL_W-1:0];
        it.cell_value = v;
        pending_ops.push_back(it);
    endtask

    // seed a small window, then mix steps, reads, writes and some noise
    task automatic queue_life_burst(int count);
        int nr;
        int nc;
        int span_r;
        int span_c;
        int r0;
        int c0;
        int k;
        int pick;
        nr     = clip_size(size_rows, lab_pkg::MAX_ROWS);
        nc     = clip_size(size_cols, lab_pkg::MAX_COLS);
        nr     = (nr == 0) ? 1 : nr;
        nc     = (nc == 0) ? 1 : nc;
        span_r = (nr < 6) ? nr : 6;
        span_c = (nc < 6) ? nc : 6;
        r0     = $urandom_range(0, nr - span_r);
        c0     = $urandom_range(0, nc - span_c);
        for (k = 0; k < count; k++)
        begin
            pick = (k < count / 3) ? 0 : $urandom_range(0, 99);
            if (pick < 30)
                post(lab_pkg::OP_WRITE, r0 + $urandom_range(0, span_r - 1),
                     c0 + $urandom_range(0, span_c - 1), $urandom_range(0, 9) < 7);
            else if (pick < 48)
                post(lab_pkg::OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1));
            else if (pick < 82)
                post(lab_pkg::OP_READ, r0 + $urandom_range(0, span_r - 1),
                     c0 + $urandom_range(0, span_c - 1), $urandom_range(0, 1));
            else if (pick < 95)
                post($urandom_range(0, 1) ? lab_pkg::OP_READ : lab_pkg::OP_WRITE,
                     $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
            else
                post(OP_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        cfg_write(REG_SPARE_LO, 7'd5);
        cfg_write(REG_SPARE_HI, 7'd127);
        set_board_size(7'd64, 7'd64);
        post(lab_pkg::OP_READ, 0, 0, 1'b0);
        post(lab_pkg::OP_WRITE, 0, 0, 1'b1);
        post(lab_pkg::OP_WRITE, 63, 63, 1'b1);
        post(lab_pkg::OP_READ, 63, 63, 1'b0);
        post(lab_pkg::OP_WRITE, 10, 9, 1'b1);
        post(lab_pkg::OP_WRITE, 10, 10, 1'b1);
        post(lab_pkg::OP_WRITE, 10, 11, 1'b1);
        post(lab_pkg::OP_ADVANCE, 0, 0, 1'b0);
        post(lab_pkg::OP_READ, 9, 10, 1'b0);
        post(lab_pkg::OP_READ, 10, 9, 1'b0);
        post(lab_pkg::OP_READ, 0, 0, 1'b0);
        post(OP_SPARE, 63, 63, 1'b1);

        set_board_size(7'd3, 7'd5);
        post(lab_pkg::OP_WRITE, 3, 0, 1'b1);
        post(lab_pkg::OP_READ, 0, 5, 1'b0);
        post(lab_pkg::OP_WRITE, 2, 4, 1'b1);
        post(lab_pkg::OP_WRITE, 1, 4, 1'b1);
        post(lab_pkg::OP_WRITE, 0, 4, 1'b1);
        post(lab_pkg::OP_ADVANCE, 63, 63, 1'b1);
        post(lab_pkg::OP_READ, 1, 3, 1'b0);

        set_board_size(7'd0, 7'd127);
        post(lab_pkg::OP_READ, 0, 0, 1'b0);
        post(lab_pkg::OP_WRITE, 0, 0, 1'b1);
        post(lab_pkg::OP_ADVANCE, 0, 0, 1'b0);

        set_board_size(7'd127, 7'd64);
        post(lab_pkg::OP_READ, 10, 10, 1'b0);
        post(lab_pkg::OP_READ, 9, 10, 1'b0);
        post(lab_pkg::OP_READ, 63, 63, 1'b0);

        set_board_size(7'd64, 7'd64);
        queue_life_burst(16);
        set_board_size(7'd8, 7'd8);
        queue_life_burst(14);
        set_board_size(7'd5, 7'd13);
        queue_life_burst(18);
        sender_idles = 1'b0;
        set_board_size(7'd1, 7'd64);
        queue_life_burst(12);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b0;
        set_board_size(7'd64, 7'd1);
        queue_life_burst(14);
        receiver_stalls = 1'b1;
        set_board_size(7'd1, 7'd1);
        queue_life_burst(10);
        set_board_size(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        queue_life_burst(14);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        set_board_size(7'd127, 7'd127);
        queue_life_burst(16);

        wait_idle();
        repeat (80) @(posedge clk);
        mismatch_count += awaited_results.size();
        $display("%0d item beats over %0d board sizes: %0d writes, %0d reads, %0d steps",
                 items_in, size_settings, writes_seen, reads_seen, steps_seen);
        $display("%0d coordinate errors predicted, %0d result beats checked, %0d mismatches",
                 errors_seen, results_out, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
